// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a consequence holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/clt_pkg.sv =====
package clt_pkg;

  // Store depths
  localparam int COMMAND_CHARS  = 16;
  localparam int ARGUMENT_CHARS = 16;
  localparam int VALUE_CHARS    = 16;

  // Length counters hold 0 .. depth
  localparam int CMD_LEN_W = $clog2(COMMAND_CHARS + 1);
  localparam int ARG_LEN_W = $clog2(ARGUMENT_CHARS + 1);
  localparam int VAL_LEN_W = $clog2(VALUE_CHARS + 1);

  // Store addresses
  localparam int CMD_ADDR_W = (COMMAND_CHARS > 1) ? $clog2(COMMAND_CHARS) : 1;
  localparam int ARG_ADDR_W = (ARGUMENT_CHARS > 1) ? $clog2(ARGUMENT_CHARS) : 1;
  localparam int VAL_ADDR_W = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;

  // Dispatch read index reaches the largest depth
  localparam int MAX_CHARS_A = (COMMAND_CHARS > ARGUMENT_CHARS) ? COMMAND_CHARS : ARGUMENT_CHARS;
  localparam int MAX_CHARS   = (MAX_CHARS_A > VALUE_CHARS) ? MAX_CHARS_A : VALUE_CHARS;
  localparam int IDX_W       = $clog2(MAX_CHARS + 1);

  // Field widths
  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ECHO = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CMD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ARG  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VAL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END  = 3'd4;

  // Parser modes
  localparam logic [1:0] MODE_CMD   = 2'd0;
  localparam logic [1:0] MODE_ARG   = 2'd1;
  localparam logic [1:0] MODE_VAL   = 2'd2;
  localparam logic [1:0] MODE_PANIC = 2'd3;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_EQUAL    = 8'h3d;
  localparam logic [CHAR_W-1:0] CH_COLON    = 8'h3a;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0d;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  // Controller to datapath
  typedef struct packed {
    logic              accept;   // take the request, load the echo
    logic              emit;     // load a dispatch result
    logic [KIND_W-1:0] kind;
    logic              last;
    logic              idx_clr;  // restart the store read index
    logic              finish;   // apply the clears held back for the dispatch
  } clt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can load this cycle
    logic dispatch;   // current request byte starts a dispatch
    logic cmd_done;
    logic arg_done;
    logic val_done;
  } clt_status_t;

endpackage

// ===== hw/rtl/clt_req_if.sv =====
interface clt_req_if import clt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/clt_res_if.sv =====
interface clt_res_if import clt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, output kind, output out_char, output last, input ready);
  modport sink (input valid, input kind, input out_char, input last, output ready);
endinterface

// ===== hw/rtl/command_line_tokenizer.sv =====
// Line tokenizer for a serial command port. Each request carries one received
// byte; lower-case letters are folded to upper case and the byte is always
// echoed back as the first result. Lines of the form CMD ARG=VAL ARG ... are
// split into command, argument and value stores of 16 characters each. Space
// or tab separates words, '=' or ':' assigns, CR or LF ends a line. Every
// completed argument or line produces a dispatch run after the echo: command
// characters, argument characters, value characters, then an end marker; the
// last result of each request has last set. Overflowing a store drops the
// character and enters panic mode, which only echoes until the next line end.
// Flow: a byte that only echoes loads just its echo. On a dispatching byte
// the single output register loads one result per cycle while the result
// side does not stall, and each of the three store phases ends with a step
// that loads nothing and restarts the registered store read. The next request
// is taken once the run ends.
module command_line_tokenizer import clt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  clt_req_if.sink    req_i,
  clt_res_if.source  res_o
);

  clt_cmd_t    cmd;
  clt_status_t status;

  // Sequence the echo and the three store phases of a dispatch
  clt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Parse, hold the stores and drive the result register
  clt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (req_i.rx_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_kind_o  (res_o.kind),
    .out_char_o  (res_o.out_char),
    .out_last_o  (res_o.last)
  );

endmodule

// ===== hw/rtl/clt_ctrl.sv =====
module clt_ctrl import clt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  clt_status_t status_i,
  output clt_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMD  = 3'd1;
  localparam logic [2:0] ST_ARG  = 3'd2;
  localparam logic [2:0] ST_VAL  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.idx_clr = 1'b1;
        if (in_valid_i && in_ready_o) begin
          cmd_o.accept = 1'b1;
          if (status_i.dispatch) begin
            state_d = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        if (status_i.cmd_done) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_ARG;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_CMD;
        end
      end
      ST_ARG: begin
        if (status_i.arg_done) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_VAL;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_ARG;
        end
      end
      ST_VAL: begin
        if (status_i.val_done) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_END;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_VAL;
        end
      end
      ST_END: begin
        if (status_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = KIND_END;
          cmd_o.last   = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/clt_datapath.sv =====
`include "assert_macros.svh"

module clt_datapath import clt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CHAR_W-1:0] rx_byte_i,
  input  clt_cmd_t          cmd_i,
  output clt_status_t       status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] out_kind_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_last_o
);

  logic [CHAR_W-1:0] store_cmd_mem [COMMAND_CHARS];
  logic [CHAR_W-1:0] store_arg_mem [ARGUMENT_CHARS];
  logic [CHAR_W-1:0] store_val_mem [VALUE_CHARS];

  logic [1:0]           mode_q, mode_d;
  logic [CMD_LEN_W-1:0] cmd_len_q, cmd_len_d;
  logic [ARG_LEN_W-1:0] arg_len_q, arg_len_d;
  logic [VAL_LEN_W-1:0] val_len_q, val_len_d;
  logic                 post_all_q, post_arg_q;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [CHAR_W-1:0]    rd_cmd_q, rd_arg_q, rd_val_q;

  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;

  logic [CHAR_W-1:0] folded;
  logic              is_sep, is_asg, is_lf;
  logic              wr_cmd, wr_arg, wr_val, dispatch;
  logic              pre_arg_clr, pre_val_clr, now_clr_all, post_all, post_arg;
  logic              out_free;
  logic [CHAR_W-1:0] emit_char;

  // Fold lower case and classify
  assign folded = ((rx_byte_i >= CH_LOWER_A) && (rx_byte_i <= CH_LOWER_Z)) ?
                  (rx_byte_i - CASE_OFFSET) : rx_byte_i;
  assign is_sep = (folded == CH_SPACE) || (folded == CH_TAB);
  assign is_asg = (folded == CH_EQUAL) || (folded == CH_COLON);
  assign is_lf  = (folded == CH_LF) || (folded == CH_CR);

  // Decide what the byte does in the current mode
  always_comb begin
    mode_d      = mode_q;
    wr_cmd      = 1'b0;
    wr_arg      = 1'b0;
    wr_val      = 1'b0;
    dispatch    = 1'b0;
    pre_arg_clr = 1'b0;
    pre_val_clr = 1'b0;
    now_clr_all = 1'b0;
    post_all    = 1'b0;
    post_arg    = 1'b0;
    case (mode_q)
      MODE_CMD: begin
        if ((cmd_len_q == '0) && (is_sep || is_lf)) begin
          mode_d = MODE_CMD;
        end else if (is_sep) begin
          pre_arg_clr = 1'b1;
          mode_d      = MODE_ARG;
        end else if (is_lf) begin
          pre_arg_clr = 1'b1;
          pre_val_clr = 1'b1;
          dispatch    = 1'b1;
          post_all    = 1'b1;
          mode_d      = MODE_CMD;
        end else if (cmd_len_q >= CMD_LEN_W'(COMMAND_CHARS)) begin
          mode_d = MODE_PANIC;
        end else begin
          wr_cmd = 1'b1;
        end
      end
      MODE_ARG: begin
        if ((arg_len_q == '0) && is_sep) begin
          mode_d = MODE_ARG;
        end else if (is_asg) begin
          pre_val_clr = 1'b1;
          mode_d      = MODE_VAL;
        end else if (is_sep) begin
          pre_val_clr = 1'b1;
          dispatch    = 1'b1;
          post_arg    = 1'b1;
          mode_d      = MODE_ARG;
        end else if (is_lf) begin
          pre_val_clr = 1'b1;
          dispatch    = 1'b1;
          post_all    = 1'b1;
          mode_d      = MODE_CMD;
        end else if (arg_len_q >= ARG_LEN_W'(ARGUMENT_CHARS)) begin
          mode_d = MODE_PANIC;
        end else begin
          wr_arg = 1'b1;
        end
      end
      MODE_VAL: begin
        if (is_sep) begin
          dispatch = 1'b1;
          post_arg = 1'b1;
          mode_d   = MODE_ARG;
        end else if (is_lf) begin
          dispatch = 1'b1;
          post_all = 1'b1;
          mode_d   = MODE_CMD;
        end else if (val_len_q >= VAL_LEN_W'(VALUE_CHARS)) begin
          mode_d = MODE_PANIC;
        end else begin
          wr_val = 1'b1;
        end
      end
      default: begin
        if (is_lf) begin
          now_clr_all = 1'b1;
          mode_d      = MODE_CMD;
        end
      end
    endcase
  end

  // Lengths: update on accept, apply held-back clears at dispatch end
  always_comb begin
    cmd_len_d = cmd_len_q;
    arg_len_d = arg_len_q;
    val_len_d = val_len_q;
    if (cmd_i.accept) begin
      if (now_clr_all) begin
        cmd_len_d = '0;
      end else if (wr_cmd) begin
        cmd_len_d = cmd_len_q + 1'b1;
      end
      if (now_clr_all || pre_arg_clr) begin
        arg_len_d = '0;
      end else if (wr_arg) begin
        arg_len_d = arg_len_q + 1'b1;
      end
      if (now_clr_all || pre_val_clr) begin
        val_len_d = '0;
      end else if (wr_val) begin
        val_len_d = val_len_q + 1'b1;
      end
    end else if (cmd_i.finish) begin
      if (post_all_q) begin
        cmd_len_d = '0;
        arg_len_d = '0;
        val_len_d = '0;
      end else if (post_arg_q) begin
        arg_len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_CMD;
      cmd_len_q  <= '0;
      arg_len_q  <= '0;
      val_len_q  <= '0;
      post_all_q <= 1'b0;
      post_arg_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      cmd_len_q <= cmd_len_d;
      arg_len_q <= arg_len_d;
      val_len_q <= val_len_d;
      idx_q     <= idx_d;
      if (cmd_i.accept) begin
        mode_q     <= mode_d;
        post_all_q <= post_all;
        post_arg_q <= post_arg;
      end
    end
  end

  // Read index: read data register holds the entry at idx_q as it stood before any write at the same edge
  assign idx_d = cmd_i.idx_clr ? '0 : (cmd_i.emit ? (idx_q + 1'b1) : idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_cmd) begin
      store_cmd_mem[cmd_len_q[CMD_ADDR_W-1:0]] <= folded;
    end
    if (cmd_i.accept && wr_arg) begin
      store_arg_mem[arg_len_q[ARG_ADDR_W-1:0]] <= folded;
    end
    if (cmd_i.accept && wr_val) begin
      store_val_mem[val_len_q[VAL_ADDR_W-1:0]] <= folded;
    end
    rd_cmd_q <= store_cmd_mem[idx_d[CMD_ADDR_W-1:0]];
    rd_arg_q <= store_arg_mem[idx_d[ARG_ADDR_W-1:0]];
    rd_val_q <= store_val_mem[idx_d[VAL_ADDR_W-1:0]];
  end

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.kind)
      KIND_CMD: emit_char = rd_cmd_q;
      KIND_ARG: emit_char = rd_arg_q;
      KIND_VAL: emit_char = rd_val_q;
      default:  emit_char = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.accept || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      out_kind_q <= KIND_ECHO;
      out_char_q <= folded;
      out_last_q <= !dispatch;
    end else if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_char_q <= emit_char;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  assign status_o.out_free = out_free;
  assign status_o.dispatch = dispatch;
  assign status_o.cmd_done = (idx_q == IDX_W'(cmd_len_q));
  assign status_o.arg_done = (idx_q == IDX_W'(arg_len_q));
  assign status_o.val_done = (idx_q == IDX_W'(val_len_q));

  `ASSERT_ALWAYS(a_len_bound, clk_i, rst_ni, (cmd_len_q <= CMD_LEN_W'(COMMAND_CHARS)) && (arg_len_q <= ARG_LEN_W'(ARGUMENT_CHARS)) && (val_len_q <= VAL_LEN_W'(VALUE_CHARS)), "store length beyond depth")
  `ASSERT_ALWAYS(a_one_load, clk_i, rst_ni, !(cmd_i.accept && cmd_i.emit), "echo and dispatch result loaded together")
  `ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, cmd_i.accept || cmd_i.emit, out_free, "output register overwritten while held")
  `ASSERT_IMPLY(a_panic_no_store, clk_i, rst_ni, mode_q == MODE_PANIC, !(wr_cmd || wr_arg || wr_val), "store written in panic mode")

endmodule
